>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the voxel unpack RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define VBUD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define VBUD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define VBUD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VBUD_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> src/vbud_pkg.sv
// ----------------------------------------------------------------------------
// vbud_pkg
// Types, codes and fixed widths of the voxel block unpack / delta datapath.
// ----------------------------------------------------------------------------
package vbud_pkg;

    localparam int ADDR_W       = 15;
    localparam int DATA_W       = 16;
    localparam int STORE_DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 3;
    localparam int OFIFO_DEPTH  = 8;
    localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);
    localparam int NIBBLE_W     = 4;
    localparam int BYTE_W       = 8;

    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_BWD = 2'd2;

    typedef enum logic [1:0] {
        SB_CONST = 2'd0,
        SB_NIB   = 2'd1,
        SB_BYTE  = 2'd2,
        SB_WORD  = 2'd3
    } t_sbits;

    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_SUB    = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_X  = 2'd0,
        CFG_COUNT_Y  = 2'd1,
        CFG_COUNT_Z  = 2'd2,
        CFG_DELTA_EN = 2'd3
    } t_cfg_idx;

    // one voxel update travelling down the pipe
    typedef struct packed {
        logic              valid;
        t_mode             mode;
        logic              last;
        logic              done;
        logic [DATA_W-1:0] value;
    } t_upd;

    // one finished result
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              done;
    } t_ores;

    // block count with zero forced to one and saturation at max_blocks
    function automatic logic [4:0] eff_count(logic [CNT_W-1:0] c, int unsigned max_blocks);
        logic [4:0] f;
        if (c == '0) begin
            f = 5'd1;
        end else if (int'(c) > int'(max_blocks)) begin
            f = 5'(max_blocks);
        end else begin
            f = 5'(c);
        end
        return f;
    endfunction

endpackage

>>> src/voxel_block_unpack_delta.sv
// ----------------------------------------------------------------------------
// voxel_block_unpack_delta
// Unpacks packed voxel units into a 16-bit voxel volume, direct or delta.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 32768-entry voxel store to zero, one entry
// per cycle, and holds o_stall high until the sweep ends. From then on it
// takes one item per cycle unless the result queue is out of credit; a
// four-bit unit that yields two voxels holds the input while its second voxel
// issues, since the store has a single read-modify-write port and each voxel
// update uses it once. An eight-entry result queue keeps the pipe full while
// the output is stalled. Write the configuration only while idle.
module voxel_block_unpack_delta
    import vbud_pkg::*;
#(
    parameter int BLOCK_EDGE          = 8,
    parameter int MAX_BLOCKS_PER_AXIS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_sample_bits,
    input  logic [DATA_W-1:0]     i_reference_value,
    input  logic [1:0]            i_delta_direction,
    input  logic [DATA_W-1:0]     i_packed_payload,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ADDR_W-1:0]     o_voxel_address,
    output logic [DATA_W-1:0]     o_voxel_value,
    output logic                  o_last_in_item,
    output logic                  o_volume_done,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_BLOCKS_PER_AXIS * BLOCK_EDGE);

    logic [CNT_W-1:0] r_cnt_x, r_cnt_y, r_cnt_z;
    logic             r_delta_en;

    t_upd              s0_upd, s2_upd;
    logic [CW-1:0]     s0_x, s0_y, s0_z;
    logic [ADDR_W-1:0] s2_addr;
    logic              busy, push, pop;
    t_ores             push_res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_x    <= CNT_W'(1);
            r_cnt_y    <= CNT_W'(1);
            r_cnt_z    <= CNT_W'(1);
            r_delta_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COUNT_X:  r_cnt_x    <= i_cfg_data;
                CFG_COUNT_Y:  r_cnt_y    <= i_cfg_data;
                CFG_COUNT_Z:  r_cnt_z    <= i_cfg_data;
                CFG_DELTA_EN: r_delta_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vbud_seq #(
        .BLOCK_EDGE          (BLOCK_EDGE),
        .MAX_BLOCKS_PER_AXIS (MAX_BLOCKS_PER_AXIS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample_bits     (i_sample_bits),
        .i_reference_value (i_reference_value),
        .i_delta_direction (i_delta_direction),
        .i_packed_payload  (i_packed_payload),
        .i_cnt_x           (r_cnt_x),
        .i_cnt_y           (r_cnt_y),
        .i_cnt_z           (r_cnt_z),
        .i_delta_en        (r_delta_en),
        .i_busy            (busy),
        .i_pop             (pop),
        .o_upd             (s0_upd),
        .o_x               (s0_x),
        .o_y               (s0_y),
        .o_z               (s0_z)
    );

    vbud_addr #(
        .BLOCK_EDGE          (BLOCK_EDGE),
        .MAX_BLOCKS_PER_AXIS (MAX_BLOCKS_PER_AXIS)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt_x (r_cnt_x),
        .i_cnt_y (r_cnt_y),
        .i_upd   (s0_upd),
        .i_x     (s0_x),
        .i_y     (s0_y),
        .i_z     (s0_z),
        .o_upd   (s2_upd),
        .o_addr  (s2_addr)
    );

    vbud_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (s2_upd),
        .i_addr  (s2_addr),
        .o_busy  (busy),
        .o_push  (push),
        .o_res   (push_res)
    );

    vbud_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_pop   (pop),
        .o_res   (out_res)
    );

    assign o_voxel_address = out_res.addr;
    assign o_voxel_value   = out_res.value;
    assign o_last_in_item  = out_res.last;
    assign o_volume_done   = out_res.done;

endmodule

>>> src/vbud_seq.sv
// ----------------------------------------------------------------------------
// vbud_seq
// Input register, voxel cursor and per-voxel update issue with output credits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbud_seq
    import vbud_pkg::*;
#(
    parameter int BLOCK_EDGE          = 8,
    parameter int MAX_BLOCKS_PER_AXIS = 4,
    localparam int CW = $clog2(MAX_BLOCKS_PER_AXIS * BLOCK_EDGE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_sample_bits,
    input  logic [DATA_W-1:0] i_reference_value,
    input  logic [1:0]        i_delta_direction,
    input  logic [DATA_W-1:0] i_packed_payload,
    input  logic [CNT_W-1:0]  i_cnt_x,
    input  logic [CNT_W-1:0]  i_cnt_y,
    input  logic [CNT_W-1:0]  i_cnt_z,
    input  logic              i_delta_en,
    input  logic              i_busy,
    input  logic              i_pop,
    output t_upd              o_upd,
    output logic [CW-1:0]     o_x,
    output logic [CW-1:0]     o_y,
    output logic [CW-1:0]     o_z
);

    localparam int IW = $clog2(BLOCK_EDGE);
    localparam int PW = (MAX_BLOCKS_PER_AXIS > 1) ? $clog2(MAX_BLOCKS_PER_AXIS) : 1;

    logic              r_in_valid;
    t_sbits            r_sb;
    logic [DATA_W-1:0] r_ref;
    logic [1:0]        r_dir;
    logic [DATA_W-1:0] r_pay;
    logic              r_half;
    logic [IW-1:0]     r_ix, r_iy, r_iz;
    logic [PW-1:0]     r_px, r_py, r_pz;
    logic [OFIFO_CNT_W-1:0] r_used;
    t_upd              r_upd;
    logic [CW-1:0]     r_x, r_y, r_z;

    logic [IW:0]       nx, ny, nz;
    logic [PW:0]       npx, npy, npz;
    logic [PW:0]       eff_x, eff_y, eff_z;
    logic              cx, cy, cz, cpz, cpy, cpx;
    logic [IW-1:0]     n_ix, n_iy, n_iz;
    logic [PW-1:0]     n_px, n_py, n_pz;
    logic              skip, pair_first, can, issue, consume, accept;
    logic [DATA_W-1:0] value_c;
    t_mode             mode_c;
    logic [CW-1:0]     x_c, y_c, z_c;
    logic [OFIFO_CNT_W-1:0] n_used;

    // cursor advance by one voxel
    always_comb begin
        eff_x = (PW+1)'(eff_count(i_cnt_x, MAX_BLOCKS_PER_AXIS));
        eff_y = (PW+1)'(eff_count(i_cnt_y, MAX_BLOCKS_PER_AXIS));
        eff_z = (PW+1)'(eff_count(i_cnt_z, MAX_BLOCKS_PER_AXIS));
        nx  = {1'b0, r_ix} + (IW+1)'(1);
        ny  = {1'b0, r_iy} + (IW+1)'(1);
        nz  = {1'b0, r_iz} + (IW+1)'(1);
        npz = {1'b0, r_pz} + (PW+1)'(1);
        npy = {1'b0, r_py} + (PW+1)'(1);
        npx = {1'b0, r_px} + (PW+1)'(1);
        cx  = (nx >= (IW+1)'(BLOCK_EDGE));
        cy  = cx && (ny >= (IW+1)'(BLOCK_EDGE));
        cz  = cy && (nz >= (IW+1)'(BLOCK_EDGE));
        cpz = cz && !(npz < eff_z);
        cpy = cpz && !(npy < eff_y);
        cpx = cpy && !(npx < eff_x);
        n_ix = cx ? '0 : nx[IW-1:0];
        n_iy = cx ? (cy ? '0 : ny[IW-1:0]) : r_iy;
        n_iz = cy ? (cz ? '0 : nz[IW-1:0]) : r_iz;
        n_pz = cz ? (cpz ? '0 : npz[PW-1:0]) : r_pz;
        n_py = cpz ? (cpy ? '0 : npy[PW-1:0]) : r_py;
        n_px = cpy ? (cpx ? '0 : npx[PW-1:0]) : r_px;
    end

    always_comb begin
        case (r_sb)
            SB_CONST: value_c = r_ref;
            SB_NIB:   value_c = r_ref + DATA_W'(r_half ? r_pay[NIBBLE_W-1:0]
                                                       : r_pay[2*NIBBLE_W-1:NIBBLE_W]);
            SB_BYTE:  value_c = r_ref + DATA_W'(r_pay[BYTE_W-1:0]);
            SB_WORD:  value_c = r_pay;
            default:  value_c = r_pay;
        endcase
        if (i_delta_en && r_dir == DIR_FWD) begin
            mode_c = MODE_ADD;
        end else if (i_delta_en && r_dir == DIR_BWD) begin
            mode_c = MODE_SUB;
        end else begin
            mode_c = MODE_DIRECT;
        end
        x_c = CW'(CW'(r_px) * CW'(BLOCK_EDGE)) + CW'(r_ix);
        y_c = CW'(CW'(r_py) * CW'(BLOCK_EDGE)) + CW'(r_iy);
        z_c = CW'(CW'(r_pz) * CW'(BLOCK_EDGE)) + CW'(r_iz);
    end

    always_comb begin
        skip       = (r_sb == SB_CONST) && (r_ref == '0);
        pair_first = (r_sb == SB_NIB) && !r_half && !cx;
        can        = r_in_valid && !i_busy
                     && (skip || (r_used < OFIFO_CNT_W'(OFIFO_DEPTH)));
        issue      = can && !skip;
        consume    = can && !pair_first;
        o_stall    = i_busy || (r_in_valid && !consume);
        accept     = i_valid && !o_stall;
        n_used     = r_used + OFIFO_CNT_W'(issue) - OFIFO_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_half     <= 1'b0;
            r_ix       <= '0;
            r_iy       <= '0;
            r_iz       <= '0;
            r_px       <= '0;
            r_py       <= '0;
            r_pz       <= '0;
            r_used     <= '0;
            r_upd.valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
                r_sb       <= t_sbits'(i_sample_bits);
                r_ref      <= i_reference_value;
                r_dir      <= i_delta_direction;
                r_pay      <= i_packed_payload;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_half <= 1'b0;
            end else if (issue) begin
                r_half <= 1'b1;
            end
            if (can) begin
                r_ix <= n_ix;
                r_iy <= n_iy;
                r_iz <= n_iz;
                r_px <= n_px;
                r_py <= n_py;
                r_pz <= n_pz;
            end
            r_used      <= n_used;
            r_upd.valid <= issue;
            if (issue) begin
                r_upd.mode  <= mode_c;
                r_upd.last  <= !pair_first;
                r_upd.done  <= cpx && !pair_first;
                r_upd.value <= value_c;
                r_x         <= x_c;
                r_y         <= y_c;
                r_z         <= z_c;
            end
        end
    end

    assign o_upd = r_upd;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

    `VBUD_NEVER(a_credit_ovf, i_clk, i_rst_n, r_used > OFIFO_CNT_W'(OFIFO_DEPTH), "credit overflow")
    `VBUD_ASSERT(a_half_held, i_clk, i_rst_n, r_half |-> r_in_valid && r_sb == SB_NIB, "lost pair")
    `VBUD_NEVER(a_issue_busy, i_clk, i_rst_n, r_upd.valid && $past(i_busy), "issue while clearing")

endmodule

>>> src/vbud_addr.sv
// ----------------------------------------------------------------------------
// vbud_addr
// Two-stage linear address computation from voxel coordinates.
// ----------------------------------------------------------------------------
module vbud_addr
    import vbud_pkg::*;
#(
    parameter int BLOCK_EDGE          = 8,
    parameter int MAX_BLOCKS_PER_AXIS = 4,
    localparam int CW = $clog2(MAX_BLOCKS_PER_AXIS * BLOCK_EDGE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_cnt_x,
    input  logic [CNT_W-1:0]  i_cnt_y,
    input  t_upd              i_upd,
    input  logic [CW-1:0]     i_x,
    input  logic [CW-1:0]     i_y,
    input  logic [CW-1:0]     i_z,
    output t_upd              o_upd,
    output logic [ADDR_W-1:0] o_addr
);

    logic [ADDR_W-1:0] r_sx, r_sy, r_sxy;
    t_upd              r_s1, r_s2;
    logic [ADDR_W-1:0] r_x1, r_ysx, r_zsxy;
    logic [ADDR_W-1:0] r_addr;

    // row and slice strides, refreshed from the count registers
    always_ff @(posedge i_clk) begin
        r_sx  <= ADDR_W'(ADDR_W'(eff_count(i_cnt_x, MAX_BLOCKS_PER_AXIS)) * ADDR_W'(BLOCK_EDGE));
        r_sy  <= ADDR_W'(ADDR_W'(eff_count(i_cnt_y, MAX_BLOCKS_PER_AXIS)) * ADDR_W'(BLOCK_EDGE));
        r_sxy <= ADDR_W'(r_sx * r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1   <= i_upd;
            r_x1   <= ADDR_W'(i_x);
            r_ysx  <= ADDR_W'(ADDR_W'(i_y) * r_sx);
            r_zsxy <= ADDR_W'(ADDR_W'(i_z) * r_sxy);
            r_s2   <= r_s1;
            r_addr <= r_x1 + r_ysx + r_zsxy;
        end
    end

    assign o_upd  = r_s2;
    assign o_addr = r_addr;

endmodule

>>> src/vbud_update.sv
// ----------------------------------------------------------------------------
// vbud_update
// Voxel store with clearing pass, read-modify-write stage and write forwarding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbud_update
    import vbud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_upd              i_upd,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_busy,
    output logic              o_push,
    output t_ores             o_res
);

    logic [DATA_W-1:0] r_mem [STORE_DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    t_upd              r_s3;
    logic [ADDR_W-1:0] r_s3_addr;
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    logic [DATA_W-1:0] old_c, nv_c;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    always_comb begin
        // the write issued at the edge of our read is not in r_rdata
        old_c = (r_fwd_valid && r_fwd_addr == r_s3_addr) ? r_fwd_data : r_rdata;
        case (r_s3.mode)
            MODE_ADD: nv_c = old_c + r_s3.value;
            MODE_SUB: nv_c = old_c - r_s3.value;
            default:  nv_c = r_s3.value;
        endcase
        mem_we    = r_clr_busy || r_s3.valid;
        mem_waddr = r_clr_busy ? r_clr_addr : r_s3_addr;
        mem_wdata = r_clr_busy ? '0 : nv_c;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s3.valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s3        <= i_upd;
            r_s3_addr   <= i_addr;
            r_fwd_valid <= r_s3.valid;
            r_fwd_addr  <= r_s3_addr;
            r_fwd_data  <= nv_c;
        end
    end

    assign o_busy = r_clr_busy;
    assign o_push = r_s3.valid;
    assign o_res  = '{addr: r_s3_addr, value: nv_c, last: r_s3.last, done: r_s3.done};

    `VBUD_NEVER(a_clear_clash, i_clk, i_rst_n, r_clr_busy && r_s3.valid, "update during clear")

endmodule

>>> src/vbud_ofifo.sv
// ----------------------------------------------------------------------------
// vbud_ofifo
// Result queue between the update pipe and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbud_ofifo
    import vbud_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_ores i_res,
    input  logic  i_stall,
    output logic  o_valid,
    output logic  o_pop,
    output t_ores o_res
);

    t_ores                  r_q [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OFIFO_CNT_W-1:0] r_count;

    logic pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_pop   = pop;
    assign o_res   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OFIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_PTR_W'(1);
            end
            r_count <= r_count + OFIFO_CNT_W'(i_push) - OFIFO_CNT_W'(pop);
        end
    end

    `VBUD_NEVER(a_push_full, i_clk, i_rst_n, i_push && r_count == OFIFO_CNT_W'(OFIFO_DEPTH), "queue overrun")

endmodule

>>> bench/tb_voxel_block_unpack_delta.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_block_unpack_delta
// Self-checking bench for the voxel block unpacker. A queue-fed driver sends
// packed units; on each accepted item an in-bench volume predictor (own voxel
// store, block cursor and registers) queues the expected voxel writes, and a
// monitor checks every accepted result against them in order. Phases change
// block counts and delta enable while idle, cover saturated and zero counts,
// a volume completed by a silent slot, and a cursor left beyond a new count.
// ----------------------------------------------------------------------------
module tb_voxel_block_unpack_delta
    import vbud_pkg::*;
();

    localparam int BLK_EDGE  = 8;
    localparam int MAX_BLK   = 4;
    localparam int CYC_LIMIT = 300000;
    localparam int DRAIN_CYC = 20;

    localparam logic [1:0] DIR_DIRECT = 2'd0;
    localparam logic [1:0] DIR_SPARE  = 2'd3;

    typedef struct {
        t_sbits      bits;
        logic [15:0] ref_val;
        logic [1:0]  dir;
        logic [15:0] payload;
    } t_unit;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_sample_bits = '0;
    logic [DATA_W-1:0]     i_reference_value = '0;
    logic [1:0]            i_delta_direction = '0;
    logic [DATA_W-1:0]     i_packed_payload = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ADDR_W-1:0]     o_voxel_address;
    logic [DATA_W-1:0]     o_voxel_value;
    logic                  o_last_in_item;
    logic                  o_volume_done;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    voxel_block_unpack_delta dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample_bits     (i_sample_bits),
        .i_reference_value (i_reference_value),
        .i_delta_direction (i_delta_direction),
        .i_packed_payload  (i_packed_payload),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_voxel_address   (o_voxel_address),
        .o_voxel_value     (o_voxel_value),
        .o_last_in_item    (o_last_in_item),
        .o_volume_done     (o_volume_done),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    t_unit       unit_q[$];
    t_ores       voxel_q[$];
    t_unit       cur_unit;
    int unsigned cyc = 0;
    int unsigned errs = 0;

    // volume predictor state
    logic [15:0] vol_mem [STORE_DEPTH];
    logic [2:0]  cnt_x = 3'd1, cnt_y = 3'd1, cnt_z = 3'd1;
    logic        delta_on = 1'b0;
    int unsigned bx = 0, by = 0, bz = 0, ix = 0, iy = 0, iz = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned span(logic [2:0] c);
        if (c == 3'd0) return 1;
        if (c > MAX_BLK) return MAX_BLK;
        return c;
    endfunction

    // one voxel step in block order; 1 when the volume wraps
    function automatic bit step_cursor();
        ix++;
        if (ix < BLK_EDGE) return 1'b0;
        ix = 0;
        iy++;
        if (iy < BLK_EDGE) return 1'b0;
        iy = 0;
        iz++;
        if (iz < BLK_EDGE) return 1'b0;
        iz = 0;
        bz++;
        if (bz < span(cnt_z)) return 1'b0;
        bz = 0;
        by++;
        if (by < span(cnt_y)) return 1'b0;
        by = 0;
        bx++;
        if (bx < span(cnt_x)) return 1'b0;
        bx = 0;
        return 1'b1;
    endfunction

    function automatic bit write_voxel(logic [15:0] val, t_mode mode, output t_ores r);
        int unsigned sx, sy, lin;
        logic [ADDR_W-1:0] adr;
        sx  = span(cnt_x) * BLK_EDGE;
        sy  = span(cnt_y) * BLK_EDGE;
        lin = (bx * BLK_EDGE + ix) + (by * BLK_EDGE + iy) * sx
            + (bz * BLK_EDGE + iz) * sx * sy;
        adr = lin[ADDR_W-1:0];
        case (mode)
            MODE_ADD: vol_mem[adr] = vol_mem[adr] + val;
            MODE_SUB: vol_mem[adr] = vol_mem[adr] - val;
            default:  vol_mem[adr] = val;
        endcase
        r.addr  = adr;
        r.value = vol_mem[adr];
        r.last  = 1'b0;
        r.done  = 1'b0;
        return step_cursor();
    endfunction

    function automatic void predict_unit(t_unit u);
        t_mode mode;
        t_ores r0, r1;
        bit    done, two;
        mode = (delta_on && (u.dir == DIR_FWD || u.dir == DIR_BWD)) ? t_mode'(u.dir)
                                                                     : MODE_DIRECT;
        two = 1'b0;
        case (u.bits)
            SB_CONST: begin
                if (u.ref_val == 16'd0) begin
                    done = step_cursor();
                    return;
                end
                done = write_voxel(u.ref_val, mode, r0);
            end
            SB_NIB: begin
                two  = (ix + 1) < BLK_EDGE;
                done = write_voxel(u.ref_val + u.payload[7:4], mode, r0);
                if (two) done = write_voxel(u.ref_val + u.payload[3:0], mode, r1);
            end
            SB_BYTE: done = write_voxel(u.ref_val + u.payload[7:0], mode, r0);
            default: done = write_voxel(u.payload, mode, r0);
        endcase
        if (two) begin
            r1.last = 1'b1;
            r1.done = done;
            voxel_q.insert(voxel_q.size(), r0);
            voxel_q.insert(voxel_q.size(), r1);
        end else begin
            r0.last = 1'b1;
            r0.done = done;
            voxel_q.insert(voxel_q.size(), r0);
        end
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            errs++;
        end
    endfunction

    function automatic void add_unit(t_sbits b, logic [15:0] r, logic [1:0] d,
                                     logic [15:0] p);
        t_unit u;
        u.bits    = b;
        u.ref_val = r;
        u.dir     = d;
        u.payload = p;
        unit_q.insert(unit_q.size(), u);
    endfunction

    function automatic logic [15:0] rand_ref();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 2) return 16'h0000;
        if (k == 2) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic void add_rand(t_sbits b);
        add_unit(b, rand_ref(), 2'($urandom_range(3)), 16'($urandom));
    endfunction

    function automatic bit busy();
        return unit_q.size() != 0 || i_valid || voxel_q.size() != 0;
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_unit(cur_unit);
            if (!i_valid || !o_stall) begin
                if (unit_q.size() != 0 &&
                    !((cyc % 3000) >= 700 && $urandom_range(99) < 17)) begin
                    cur_unit = unit_q.pop_front();
                    i_sample_bits     <= cur_unit.bits;
                    i_reference_value <= cur_unit.ref_val;
                    i_delta_direction <= cur_unit.dir;
                    i_packed_payload  <= cur_unit.payload;
                    i_valid           <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_ores want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (voxel_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got addr %h value %h",
                             $time, o_voxel_address, o_voxel_value);
                    errs++;
                end else begin
                    want = voxel_q.pop_front();
                    check_field("voxel_address", 16'(want.addr), 16'(o_voxel_address));
                    check_field("voxel_value", want.value, o_voxel_value);
                    check_field("last_in_item", 16'(want.last), 16'(o_last_in_item));
                    check_field("volume_done", 16'(want.done), 16'(o_volume_done));
                end
            end
            i_stall <= ((cyc + 1500) % 3000) >= 700 && $urandom_range(99) < 17;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [2:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_COUNT_X: cnt_x = val;
            CFG_COUNT_Y: cnt_y = val;
            CFG_COUNT_Z: cnt_z = val;
            default:     delta_on = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (busy());
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [2:0] cx, logic [2:0] cy, logic [2:0] cz, logic den,
                             int n, int nib_pct);
        wait_drained();
        write_reg(CFG_COUNT_X, cx);
        write_reg(CFG_COUNT_Y, cy);
        write_reg(CFG_COUNT_Z, cz);
        write_reg(CFG_DELTA_EN, {2'b00, den});
        @(negedge i_clk);
        repeat (n) begin
            if ($urandom_range(99) < nib_pct) add_rand(SB_NIB);
            else add_rand(t_sbits'($urandom_range(3)));
        end
    endtask

    initial begin
        int rem, x;
        for (int a = 0; a < STORE_DEPTH; a++) vol_mem[a] = 16'h0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        do @(negedge i_clk); while (o_stall);

        // directed: one 8x8x8 block, delta allowed
        run_phase(3'd1, 3'd1, 3'd1, 1'b1, 0, 0);
        add_unit(SB_CONST, 16'h0000, DIR_FWD,    16'hFFFF);
        add_unit(SB_CONST, 16'hFFFF, DIR_FWD,    16'h0000);
        add_unit(SB_WORD,  16'h0000, DIR_DIRECT, 16'hFFFF);
        add_unit(SB_WORD,  16'hFFFF, DIR_BWD,    16'h0000);
        add_unit(SB_BYTE,  16'hFFFF, DIR_FWD,    16'h00FF);
        add_unit(SB_NIB,   16'h0000, DIR_SPARE,  16'h00F0);
        add_unit(SB_NIB,   16'h1234, DIR_FWD,    16'hFFFF);  // last x: low nibble dropped
        add_unit(SB_NIB,   16'hFFFF, DIR_BWD,    16'hFF0F);
        add_unit(SB_BYTE,  16'h0000, DIR_DIRECT, 16'hFF00);
        add_unit(SB_WORD,  16'h0000, DIR_FWD,    16'hAAAA);
        add_unit(SB_WORD,  16'hFFFF, DIR_BWD,    16'h5555);
        add_unit(SB_WORD,  16'h0000, DIR_SPARE,  16'hFFFF);
        add_unit(SB_CONST, 16'h8000, DIR_BWD,    16'h1234);
        add_unit(SB_NIB,   16'h0000, DIR_DIRECT, 16'h0000);
        add_unit(SB_CONST, 16'h7FFF, DIR_SPARE,  16'hFFFF);
        add_unit(SB_BYTE,  16'hFF80, DIR_BWD,    16'hFF80);

        // run to the end of the volume, closing on a silent constant slot
        wait_drained();
        rem = BLK_EDGE * BLK_EDGE * BLK_EDGE - (ix + iy * BLK_EDGE + iz * BLK_EDGE * BLK_EDGE);
        x   = ix;
        while (rem > 1) begin
            if (x == BLK_EDGE - 1) begin
                add_rand(SB_NIB);
                rem -= 1;
                x = 0;
            end else if (rem > 2) begin
                add_rand(SB_NIB);
                rem -= 2;
                x = (x + 2) % BLK_EDGE;
            end else begin
                add_rand(SB_BYTE);
                rem -= 1;
                x++;
            end
        end
        add_unit(SB_CONST, 16'h0000, DIR_FWD, 16'($urandom));
        add_unit(SB_WORD,  16'($urandom), DIR_FWD, 16'($urandom));

        run_phase(3'd0, 3'd0, 3'd0, 1'b0, 250, 50);
        run_phase(3'd1, 3'd1, 3'd1, 1'b1, 250, 50);
        run_phase(3'd7, 3'd7, 3'd7, 1'b1, 350, 60);
        // z count drops below the cursor's block
        run_phase(3'd4, 3'd2, 3'd1, 1'b1, 300, 60);
        run_phase(3'd2, 3'd3, 3'd2, 1'b0, 60, 30);

        wait_drained();
        if (errs == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
